FILE: design/dmfp_pkg.sv
// ----------------------------------------------------------------------------
// DNS message field parser package
// Shared constants, field offsets, result item and queue control types.
// ----------------------------------------------------------------------------
package dmfp_pkg;

  // Message byte index width; the index saturates at its all-ones value
  localparam int unsigned IndexBits = 16;
  typedef logic [IndexBits-1:0] idx_t;
  localparam idx_t IdxMax = {IndexBits{1'b1}};

  // Framing prefix register
  localparam int unsigned PrefixBits = 4;
  localparam logic [PrefixBits-1:0] PrefixReset = 4'd2;

  // Header offsets, relative to the end of the framing prefix
  localparam idx_t FlagsOfs = idx_t'(2);
  localparam idx_t AncHiOfs = idx_t'(6);
  localparam idx_t AncLoOfs = idx_t'(7);
  localparam idx_t QnameOfs = idx_t'(12);

  // Distances past the name terminator
  localparam idx_t QtypeHiDist  = idx_t'(1);
  localparam idx_t QtypeLoDist  = idx_t'(2);
  localparam idx_t AnTypeHiDist = idx_t'(7);
  localparam idx_t AnTypeLoDist = idx_t'(8);
  localparam idx_t RdataFirst   = idx_t'(17);
  localparam idx_t RdataLast    = idx_t'(32);

  localparam logic [15:0] TypeAaaa = 16'd28;
  localparam logic [7:0]  DotChar  = 8'h2E;
  localparam int unsigned LabelBits = 6;

  // Name walk state, one-hot
  typedef enum logic [2:0] {
    PhBefore = 3'b001,
    PhIn     = 3'b010,
    PhAfter  = 3'b100
  } name_phase_e;

  // Result item kinds
  typedef enum logic [1:0] {
    KindName    = 2'd0,
    KindAddr    = 2'd1,
    KindSummary = 2'd2
  } out_kind_e;

  typedef struct packed {
    out_kind_e   out_kind;
    logic [7:0]  out_byte;
    logic        qr_bit;
    logic        aaaa_query;
    logic [15:0] answer_count;
    logic        answer_aaaa;
    logic        malformed;
    logic        out_last;
  } item_t;

  // Result queue
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrBits = $clog2(QDepth);
  localparam int unsigned QCntBits = $clog2(QDepth + 1);
  // Room for the two items one byte can cause
  localparam logic [QCntBits-1:0] QRoomMax = QCntBits'(QDepth - 2);

  // Items produced by one input transfer, packed from slot 0
  typedef struct packed {
    logic [1:0]       cnt;
    item_t [1:0]      item;
  } push_t;

  typedef struct packed {
    logic has_item;
    logic has_room;
  } qstat_t;

endpackage

FILE: design/dmfp_if.sv
// ----------------------------------------------------------------------------
// DNS message field parser channels
// Valid/ready stream interfaces for message bytes and result items.
// ----------------------------------------------------------------------------

// Message byte stream
interface dmfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       msg_last;

  modport source (output valid, output msg_byte, output msg_last, input ready);
  modport sink   (input valid, input msg_byte, input msg_last, output ready);
endinterface

// Result item stream
interface dmfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic        qr_bit;
  logic        aaaa_query;
  logic [15:0] answer_count;
  logic        answer_aaaa;
  logic        malformed;
  logic        out_last;

  modport source (
    output valid, output out_kind, output out_byte, output qr_bit,
    output aaaa_query, output answer_count, output answer_aaaa,
    output malformed, output out_last, input ready
  );
  modport sink (
    input valid, input out_kind, input out_byte, input qr_bit,
    input aaaa_query, input answer_count, input answer_aaaa,
    input malformed, input out_last, output ready
  );
endinterface

FILE: design/dmfp_parse.sv
// ----------------------------------------------------------------------------
// DNS message field parser - byte parser
// Per-message state and the combinational next-state update for one message byte.
// ----------------------------------------------------------------------------
module dmfp_parse (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dmfp_pkg::PrefixBits-1:0] cfg_wdata_i,
  input  logic                           accept_i,
  input  logic [7:0]                     msg_byte_i,
  input  logic                           msg_last_i,
  output dmfp_pkg::push_t                push_o
);

  logic [dmfp_pkg::PrefixBits-1:0] prefix_q;
  dmfp_pkg::idx_t                  idx_q, idx_d;
  logic [dmfp_pkg::LabelBits-1:0]  lab_q, lab_d;
  dmfp_pkg::name_phase_e           phase_q, phase_d;
  logic                            first_q, first_d;
  dmfp_pkg::idx_t                  end_q, end_d;
  logic [7:0]                      held_q, held_d;
  logic                            qr_q, qr_d;
  logic                            aaaa_q, aaaa_d;
  logic [15:0]                     anc_q, anc_d;
  logic                            type_ok_q, type_ok_d;
  logic                            err_q, err_d;

  dmfp_pkg::idx_t  p_ext;
  dmfp_pkg::idx_t  dist_cur;
  dmfp_pkg::idx_t  dist_last;
  logic [15:0]     word;
  logic            wanted_q, wanted_d;
  logic            early;
  logic            data_vld;
  dmfp_pkg::item_t data_item;
  dmfp_pkg::item_t sum_item;

  // Prefix length register; write it only while idle (the block does not enforce this)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= dmfp_pkg::PrefixReset;
    end else if (cfg_we_i) begin
      prefix_q <= cfg_wdata_i;
    end
  end

  assign p_ext    = dmfp_pkg::idx_t'(prefix_q);
  assign dist_cur = idx_q - end_q;
  assign word     = {held_q, msg_byte_i};
  assign wanted_q = qr_q && (anc_q != 16'd0) && type_ok_q;

  // Field extraction and name walk for the current byte
  always_comb begin
    idx_d     = idx_q;
    lab_d     = lab_q;
    phase_d   = phase_q;
    first_d   = first_q;
    end_d     = end_q;
    held_d    = held_q;
    qr_d      = qr_q;
    aaaa_d    = aaaa_q;
    anc_d     = anc_q;
    type_ok_d = type_ok_q;
    err_d     = err_q;
    data_vld  = 1'b0;
    data_item = '0;

    if (idx_q != dmfp_pkg::IdxMax) begin
      if (idx_q == p_ext + dmfp_pkg::FlagsOfs) qr_d = msg_byte_i[7];
      if (idx_q == p_ext + dmfp_pkg::AncHiOfs) held_d = msg_byte_i;
      if (idx_q == p_ext + dmfp_pkg::AncLoOfs) anc_d = word;

      if (phase_q != dmfp_pkg::PhAfter && idx_q >= p_ext + dmfp_pkg::QnameOfs) begin
        phase_d = dmfp_pkg::PhIn;
        if (lab_q == '0) begin
          // Length byte: zero ends the name, over 63 ends it as malformed
          if (msg_byte_i == 8'd0 || msg_byte_i[7:6] != 2'd0) begin
            if (msg_byte_i != 8'd0) err_d = 1'b1;
            phase_d = dmfp_pkg::PhAfter;
            end_d   = idx_q;
          end else begin
            if (first_q) begin
              data_vld           = 1'b1;
              data_item.out_kind = dmfp_pkg::KindName;
              data_item.out_byte = dmfp_pkg::DotChar;
            end
            first_d = 1'b1;
            lab_d   = msg_byte_i[dmfp_pkg::LabelBits-1:0];
          end
        end else begin
          data_vld           = 1'b1;
          data_item.out_kind = dmfp_pkg::KindName;
          data_item.out_byte = msg_byte_i;
          lab_d              = lab_q - 1'b1;
        end
      end else if (phase_q == dmfp_pkg::PhAfter && idx_q > end_q) begin
        // Fields at fixed distances past the name terminator
        if (dist_cur == dmfp_pkg::QtypeHiDist || dist_cur == dmfp_pkg::AnTypeHiDist) begin
          held_d = msg_byte_i;
        end else if (dist_cur == dmfp_pkg::QtypeLoDist) begin
          aaaa_d = (word == dmfp_pkg::TypeAaaa);
        end else if (dist_cur == dmfp_pkg::AnTypeLoDist) begin
          type_ok_d = (word == dmfp_pkg::TypeAaaa);
        end else if (dist_cur >= dmfp_pkg::RdataFirst && dist_cur <= dmfp_pkg::RdataLast &&
                     wanted_q) begin
          data_vld           = 1'b1;
          data_item.out_kind = dmfp_pkg::KindAddr;
          data_item.out_byte = msg_byte_i;
        end
      end
      idx_d = idx_q + 1'b1;
    end

    // Summary, from the state after this byte
    dist_last = idx_q - end_d;
    wanted_d  = qr_d && (anc_d != 16'd0) && type_ok_d;
    early     = (phase_d != dmfp_pkg::PhAfter) || (idx_q < end_d) ||
                (dist_last < dmfp_pkg::QtypeLoDist) ||
                (qr_d && anc_d != 16'd0 && dist_last < dmfp_pkg::AnTypeLoDist) ||
                (wanted_d && dist_last < dmfp_pkg::RdataLast);

    sum_item              = '0;
    sum_item.out_kind     = dmfp_pkg::KindSummary;
    sum_item.qr_bit       = qr_d;
    sum_item.aaaa_query   = aaaa_d;
    sum_item.answer_count = anc_d;
    sum_item.answer_aaaa  = wanted_d;
    sum_item.malformed    = err_d || early;
    sum_item.out_last     = 1'b1;

    // Last byte restarts the message; the prefix length is kept
    if (msg_last_i) begin
      idx_d     = '0;
      lab_d     = '0;
      phase_d   = dmfp_pkg::PhBefore;
      first_d   = 1'b0;
      end_d     = '0;
      held_d    = '0;
      qr_d      = 1'b0;
      aaaa_d    = 1'b0;
      anc_d     = '0;
      type_ok_d = 1'b0;
      err_d     = 1'b0;
    end
  end

  // Items for the result queue, packed from slot 0
  always_comb begin
    push_o         = '0;
    push_o.item[0] = data_vld ? data_item : sum_item;
    push_o.item[1] = sum_item;
    if (accept_i) begin
      push_o.cnt = {1'b0, data_vld} + {1'b0, msg_last_i};
    end
  end

  // Message state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      lab_q     <= '0;
      phase_q   <= dmfp_pkg::PhBefore;
      first_q   <= 1'b0;
      end_q     <= '0;
      held_q    <= '0;
      qr_q      <= 1'b0;
      aaaa_q    <= 1'b0;
      anc_q     <= '0;
      type_ok_q <= 1'b0;
      err_q     <= 1'b0;
    end else if (accept_i) begin
      idx_q     <= idx_d;
      lab_q     <= lab_d;
      phase_q   <= phase_d;
      first_q   <= first_d;
      end_q     <= end_d;
      held_q    <= held_d;
      qr_q      <= qr_d;
      aaaa_q    <= aaaa_d;
      anc_q     <= anc_d;
      type_ok_q <= type_ok_d;
      err_q     <= err_d;
    end
  end

endmodule

FILE: design/dmfp_outq.sv
// ----------------------------------------------------------------------------
// DNS message field parser - result queue
// Small queue that takes up to two items per cycle and hands out one.
// ----------------------------------------------------------------------------
module dmfp_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dmfp_pkg::push_t  push_i,
  input  logic             pop_i,
  output dmfp_pkg::item_t  head_o,
  output dmfp_pkg::qstat_t stat_o
);

  dmfp_pkg::item_t                    mem_q [dmfp_pkg::QDepth];
  logic [dmfp_pkg::QPtrBits-1:0]      rd_q, rd_d;
  logic [dmfp_pkg::QCntBits-1:0]      cnt_q, cnt_d;
  logic [dmfp_pkg::QPtrBits-1:0]      wr0, wr1;

  assign wr0 = rd_q + cnt_q[dmfp_pkg::QPtrBits-1:0];
  assign wr1 = wr0 + 1'b1;

  assign head_o          = mem_q[rd_q];
  assign stat_o.has_item = (cnt_q != '0);
  assign stat_o.has_room = (cnt_q <= dmfp_pkg::QRoomMax);

  // Occupancy and read pointer
  always_comb begin
    rd_d  = rd_q + dmfp_pkg::QPtrBits'(pop_i);
    cnt_d = cnt_q + dmfp_pkg::QCntBits'(push_i.cnt) - dmfp_pkg::QCntBits'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Item storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr0] <= push_i.item[0];
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr1] <= push_i.item[1];
    end
  end

endmodule

FILE: design/dns_message_field_parser_core.sv
// ----------------------------------------------------------------------------
// DNS message field parser core
// Streams question name, AAAA answer address and a per-message summary.
// ----------------------------------------------------------------------------
// Usage:
//   msg_i carries one message byte per transfer, msg_last marking the final
//   byte. res_o carries result items: name characters and dots, IPv6 address
//   bytes, and one summary item (out_last set) after the final byte.
//   cfg_we_i/cfg_wdata_i write the framing prefix length; write it only while
//   no message is in flight.
// Items of a byte are registered in the result queue and reach res_o from its head.
// Throughput: one byte per cycle while the queue has room. A byte causes at
//   most two items; the result queue (four entries) holds them and input is
//   taken while at most two items wait, so a final byte that also carries a
//   name or address item leaves two items for res_o to hand out.
// Reset: the queue empties, the message state clears and the prefix length
//   returns to two.
// Stall: when res_o is not taken, items wait in the queue and msg_i.ready
//   drops once fewer than two entries are free; nothing is lost.
// ----------------------------------------------------------------------------
module dns_message_field_parser_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dmfp_pkg::PrefixBits-1:0] cfg_wdata_i,
  dmfp_in_if.sink                         msg_i,
  dmfp_out_if.source                      res_o
);

  logic             accept;
  logic             pop;
  dmfp_pkg::push_t  push;
  dmfp_pkg::item_t  head;
  dmfp_pkg::qstat_t qstat;

  // Handshakes
  assign msg_i.ready = qstat.has_room;
  assign accept      = msg_i.valid && qstat.has_room;
  assign pop         = qstat.has_item && res_o.ready;

  dmfp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .msg_byte_i  (msg_i.msg_byte),
    .msg_last_i  (msg_i.msg_last),
    .push_o      (push)
  );

  dmfp_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  // Result channel
  assign res_o.valid        = qstat.has_item;
  assign res_o.out_kind     = head.out_kind;
  assign res_o.out_byte     = head.out_byte;
  assign res_o.qr_bit       = head.qr_bit;
  assign res_o.aaaa_query   = head.aaaa_query;
  assign res_o.answer_count = head.answer_count;
  assign res_o.answer_aaaa  = head.answer_aaaa;
  assign res_o.malformed    = head.malformed;
  assign res_o.out_last     = head.out_last;

endmodule

FILE: design/dmfp_checker.sv
// ----------------------------------------------------------------------------
// DNS message field parser checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
module dmfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_kind_i,
  input logic [7:0]  out_byte_i,
  input logic        qr_bit_i,
  input logic [15:0] answer_count_i,
  input logic        answer_aaaa_i,
  input logic        out_last_i
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
                                    $stable(out_kind_i))
    else $error("result changed while stalled");

  // Only the summary closes a message, and it carries no byte
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_last_i |-> out_kind_i == dmfp_pkg::KindSummary &&
                                  out_byte_i == 8'd0)
    else $error("last flag on a non-summary item");

  // Summary always closes a message
  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == dmfp_pkg::KindSummary |-> out_last_i)
    else $error("summary without last flag");

  // An AAAA answer needs a response with answers
  a_aaaa_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && answer_aaaa_i |-> qr_bit_i && answer_count_i != 16'd0)
    else $error("answer_aaaa without response answers");

endmodule

bind dns_message_field_parser_core dmfp_checker u_dmfp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .out_kind_i     (res_o.out_kind),
  .out_byte_i     (res_o.out_byte),
  .qr_bit_i       (res_o.qr_bit),
  .answer_count_i (res_o.answer_count),
  .answer_aaaa_i  (res_o.answer_aaaa),
  .out_last_i     (res_o.out_last)
);
